FILE: rtl/sbr_pkg.sv
// Shared constants, command/status structs and controller state codes
// for the spectrum band reducer. No dependencies.
`default_nettype none

package sbr_pkg;

    // Frame geometry
    localparam int BANDS   = 75;
    localparam int POS_W   = $clog2(BANDS);
    localparam int CNT_W   = $clog2(BANDS + 1);
    localparam int SCALE_W = $clog2(BANDS * BANDS + BANDS + 1);

    // Fixed field widths
    localparam int VAL_W  = 8;
    localparam int SUM_W  = 15;
    localparam int CFG_W  = 7;
    localparam int GRP_W  = CFG_W + 1;
    localparam int IDX_W  = 2;
    localparam int ITER_W = $clog2(SUM_W);

    localparam logic [CFG_W-1:0] OBC_RESET = 7'd75;
    localparam logic [GRP_W-1:0] BANDS_G   = GRP_W'(BANDS);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_OUT_BAND_COUNT = 2'd0,
        REG_SELECT_MODE    = 2'd1
    } reg_index_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_PICK   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_pick;
        logic load_result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pick_first;
        logic close;
        logic close_pending;
        logic pick_mode;
        logic out_free;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/spectrum_band_reducer.sv
// Top level of the spectrum band reducer: joins controller and datapath.
// Depends on sbr_pkg, sbr_ctrl, sbr_datapath (and sbr_divider beneath it).
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_tvalid / s_tready   s_tdata: band_value
//  m_        out        m_tvalid / m_tready   m_tdata: out_value, m_tlast: last_of_frame
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (register value)
//
// A band that causes no result leaves the controller idle; band zero in pick mode passes
// ST_PICK, then ST_RESULT when it also closes its group; any other band that closes a group
// passes ST_RESULT in pick mode, or ST_DIVIDE then ST_RESULT in average mode, where the
// bit-serial divider gives one quotient bit per cycle over the 15-bit group sum.
// Reset (aresetn low, synchronous) restores 75 groups, average mode, frame start.
// A stalled m_ side holds the controller in its load state; no input is taken
// until all results of the current band are in the result register.
`default_nettype none

module spectrum_band_reducer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sbr_pkg::VAL_W-1:0] s_tdata,   // [7:0] band_value
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [sbr_pkg::VAL_W-1:0] m_tdata,   // [7:0] out_value
    output logic                           m_tlast,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [sbr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [sbr_pkg::CFG_W-1:0] cfg_data
);

    sbr_pkg::cmd_t    cmd;
    sbr_pkg::status_t st;

    // Configuration writes are taken at any time
    assign cfg_ready = 1'b1;

    sbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sbr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

FILE: rtl/sbr_divider.sv
// Iterative restoring divider for the group mean, one quotient bit a cycle.
// Depends on sbr_pkg.
`default_nettype none

module sbr_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [sbr_pkg::SUM_W-1:0] dividend,
    input  wire logic [sbr_pkg::CNT_W-1:0] divisor,
    output logic                           done,
    output logic      [sbr_pkg::SUM_W-1:0] quotient
);

    localparam logic [sbr_pkg::ITER_W-1:0] LAST_ITER = sbr_pkg::ITER_W'(sbr_pkg::SUM_W - 1);

    logic                        busy_reg, busy_next;
    logic [sbr_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic [sbr_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [sbr_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [sbr_pkg::CNT_W-1:0]   dsr_reg, dsr_next;
    logic [sbr_pkg::CNT_W:0]     trial;
    logic [sbr_pkg::CNT_W:0]     diff;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[sbr_pkg::SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[sbr_pkg::CNT_W-1:0];
                quo_next = {quo_reg[sbr_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[sbr_pkg::CNT_W-1:0];
                quo_next = {quo_reg[sbr_pkg::SUM_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // Final step is taken in this cycle; quotient is whole on the next
    assign done     = busy_reg && (iter_reg == LAST_ITER);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/sbr_datapath.sv
// Datapath: configuration registers, frame accumulators, group close test,
// divider and result register. Depends on sbr_pkg and sbr_divider.
`default_nettype none

module sbr_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [sbr_pkg::VAL_W-1:0] s_tdata,
    input  wire logic                      cfg_valid,
    input  wire logic [sbr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [sbr_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic      [sbr_pkg::VAL_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  wire sbr_pkg::cmd_t             cmd,
    output sbr_pkg::status_t               st
);

    logic [sbr_pkg::CFG_W-1:0]   obc_reg;
    logic                        mode_reg;
    logic [sbr_pkg::POS_W-1:0]   pos_reg;
    logic [sbr_pkg::SUM_W-1:0]   sum_reg;
    logic [sbr_pkg::CNT_W-1:0]   cnt_reg;
    logic [sbr_pkg::SCALE_W-1:0] scaled_reg;
    logic [sbr_pkg::SCALE_W-1:0] thr_reg;
    logic [sbr_pkg::VAL_W-1:0]   hold_reg;
    logic                        close_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic [sbr_pkg::VAL_W-1:0]   out_data_reg;
    logic                        out_last_reg;

    logic [sbr_pkg::GRP_W-1:0]   obc_ext;
    logic [sbr_pkg::GRP_W-1:0]   groups;
    logic                        last_now;
    logic [sbr_pkg::SCALE_W-1:0] scaled_now;
    logic                        close_now;
    logic [sbr_pkg::SUM_W-1:0]   sum_now;
    logic [sbr_pkg::CNT_W-1:0]   cnt_now;
    logic                        cfg_hit;
    logic                        div_done;
    logic [sbr_pkg::SUM_W-1:0]   quotient;

    // Clamp the group count to 1..BANDS
    always_comb begin
        obc_ext = {1'b0, obc_reg};
        if (obc_ext == '0) begin
            groups = sbr_pkg::GRP_W'(1);
        end else if (obc_ext > sbr_pkg::BANDS_G) begin
            groups = sbr_pkg::BANDS_G;
        end else begin
            groups = obc_ext;
        end
    end

    // Group close test for the band on the input
    always_comb begin
        last_now   = (pos_reg == sbr_pkg::POS_W'(sbr_pkg::BANDS - 1));
        scaled_now = scaled_reg + sbr_pkg::SCALE_W'(groups);
        close_now  = (scaled_now >= thr_reg) || last_now;
        sum_now    = sum_reg + sbr_pkg::SUM_W'(s_tdata);
        cnt_now    = cnt_reg + 1'b1;
        cfg_hit    = cfg_valid && ((cfg_index == sbr_pkg::REG_OUT_BAND_COUNT) ||
                                   (cfg_index == sbr_pkg::REG_SELECT_MODE));
    end

    // Configuration and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obc_reg    <= sbr_pkg::OBC_RESET;
            mode_reg   <= 1'b0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            scaled_reg <= '0;
            thr_reg    <= sbr_pkg::SCALE_W'(sbr_pkg::BANDS);
        end else if (cfg_hit) begin
            if (cfg_index == sbr_pkg::REG_OUT_BAND_COUNT) begin
                obc_reg <= cfg_data;
            end else begin
                mode_reg <= cfg_data[0];
            end
            pos_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            scaled_reg <= '0;
            thr_reg    <= sbr_pkg::SCALE_W'(sbr_pkg::BANDS);
        end else if (cmd.accept) begin
            if (last_now) begin
                pos_reg    <= '0;
                sum_reg    <= '0;
                cnt_reg    <= '0;
                scaled_reg <= '0;
                thr_reg    <= sbr_pkg::SCALE_W'(sbr_pkg::BANDS);
            end else begin
                pos_reg    <= pos_reg + 1'b1;
                scaled_reg <= scaled_now;
                if (close_now) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    thr_reg <= thr_reg + sbr_pkg::SCALE_W'(sbr_pkg::BANDS);
                end else begin
                    sum_reg <= sum_now;
                    cnt_reg <= cnt_now;
                end
            end
        end
    end

    // Hold the accepted band and its close decision
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hold_reg  <= s_tdata;
            close_reg <= close_now;
            last_reg  <= last_now;
        end
    end

    sbr_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_now),
        .divisor  (cnt_now),
        .done     (div_done),
        .quotient (quotient)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_pick || cmd.load_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_pick) begin
            out_data_reg <= hold_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.load_result) begin
            out_data_reg <= mode_reg ? hold_reg : quotient[sbr_pkg::VAL_W-1:0];
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        st.pick_first    = mode_reg && (pos_reg == '0);
        st.close         = close_now;
        st.close_pending = close_reg;
        st.pick_mode     = mode_reg;
        st.out_free      = !out_valid_reg || m_tready;
        st.div_done      = div_done;
    end

endmodule

`default_nettype wire

FILE: rtl/sbr_ctrl.sv
// Controller state machine: sequences accept, division and result loads.
// Depends on sbr_pkg.
`default_nettype none

module sbr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sbr_pkg::status_t st,
    output sbr_pkg::cmd_t         cmd
);

    sbr_pkg::state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next      = state_reg;
        s_tready        = (state_reg == sbr_pkg::ST_IDLE);
        cmd.accept      = s_tready && s_tvalid;
        cmd.div_start   = 1'b0;
        cmd.load_pick   = 1'b0;
        cmd.load_result = 1'b0;
        unique case (state_reg)
            sbr_pkg::ST_IDLE: begin
                if (cmd.accept) begin
                    cmd.div_start = st.close && !st.pick_mode;
                    priority if (st.pick_first) begin
                        state_next = sbr_pkg::ST_PICK;
                    end else if (st.close && st.pick_mode) begin
                        state_next = sbr_pkg::ST_RESULT;
                    end else if (st.close) begin
                        state_next = sbr_pkg::ST_DIVIDE;
                    end
                end
            end
            sbr_pkg::ST_DIVIDE: begin
                if (st.div_done) begin
                    state_next = sbr_pkg::ST_RESULT;
                end
            end
            sbr_pkg::ST_PICK: begin
                if (st.out_free) begin
                    cmd.load_pick = 1'b1;
                    state_next    = st.close_pending ? sbr_pkg::ST_RESULT : sbr_pkg::ST_IDLE;
                end
            end
            sbr_pkg::ST_RESULT: begin
                if (st.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = sbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A division always follows its start
    a_div_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (state_reg == sbr_pkg::ST_DIVIDE))
        else $error("division started without entering divide state");

    // Divider finishes only while the controller waits for it
    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_done |-> (state_reg == sbr_pkg::ST_DIVIDE))
        else $error("divider done outside divide state");

    // Never overwrite a result that has not been taken
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pick || cmd.load_result) |-> st.out_free)
        else $error("result register overwritten");

    // Band zero pick is followed by its group result when that group closed
    a_pick_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pick && st.close_pending) |=> (state_reg == sbr_pkg::ST_RESULT))
        else $error("second result after pick lost");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for spectrum_band_reducer: directed table, then random frames.
// Depends on sbr_pkg and the RTL of spectrum_band_reducer; a local predictor gives
// the expected results.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;   // covers the longest band, one that needs a division
    localparam int END_CYCLES   = 40;
    localparam int IDLE_PCT     = 37;
    localparam int PHASES       = 7;

    // Indexes that the block has no register for
    localparam logic [sbr_pkg::IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [sbr_pkg::IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [sbr_pkg::VAL_W-1:0] value;
        logic                      last;
    } band_result_t;

    typedef enum {ROW_BAND, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [sbr_pkg::IDX_W-1:0] idx;
        logic [sbr_pkg::CFG_W-1:0] data;
        logic [sbr_pkg::VAL_W-1:0] band;
        bit                        checked;
        band_result_t              want;
    } plan_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [sbr_pkg::VAL_W-1:0] s_tdata   = '0;   // [7:0] band_value
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [sbr_pkg::VAL_W-1:0] m_tdata;          // [7:0] out_value
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [sbr_pkg::IDX_W-1:0] cfg_index = '0;
    logic [sbr_pkg::CFG_W-1:0] cfg_data  = '0;

    spectrum_band_reducer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state and register copies
    logic [sbr_pkg::CFG_W-1:0] group_setting = sbr_pkg::OBC_RESET;
    logic             pick_mode     = 1'b0;
    logic [6:0]       band_pos      = '0;
    logic [14:0]      band_sum      = '0;
    logic [6:0]       band_cnt      = '0;
    logic [12:0]      scaled_pos    = '0;
    logic [12:0]      close_mark    = 13'(sbr_pkg::BANDS);

    band_result_t pending_q[$];   // results still to come out of the block
    band_result_t fresh_q[$];     // results caused by the latest band
    int           errors  = 0;
    int           cycles  = 0;
    bit           steady  = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void restart_frame();
        band_pos   = '0;
        band_sum   = '0;
        band_cnt   = '0;
        scaled_pos = '0;
        close_mark = 13'(sbr_pkg::BANDS);
    endfunction

    function automatic void push_result(input logic [sbr_pkg::VAL_W-1:0] value,
                                        input logic last);
        band_result_t r;
        r.value = value;
        r.last  = last;
        pending_q = {pending_q, r};
        fresh_q   = {fresh_q, r};
    endfunction

    // Work out the results that one accepted band causes
    function automatic void predict_band(input logic [sbr_pkg::VAL_W-1:0] v);
        logic [6:0]  groups;
        logic [6:0]  p;
        logic        frame_end;
        logic [14:0] quot;
        fresh_q.delete();
        if (group_setting == 0)
            groups = 7'd1;
        else if (int'(group_setting) > sbr_pkg::BANDS)
            groups = 7'(sbr_pkg::BANDS);
        else
            groups = group_setting;
        p         = band_pos;
        frame_end = (int'(p) + 1 >= sbr_pkg::BANDS);

        // Band zero is passed straight through in pick mode
        if (pick_mode && p == 0)
            push_result(v, 1'b0);

        band_sum   = band_sum + 15'(v);
        band_cnt   = band_cnt + 7'd1;
        scaled_pos = 13'((int'(p) + 1) * int'(groups));

        if (scaled_pos >= close_mark || frame_end) begin
            if (pick_mode)
                quot = 15'(v);
            else
                quot = (band_cnt != 0) ? band_sum / 15'(band_cnt) : '0;
            push_result(quot[sbr_pkg::VAL_W-1:0], frame_end);
            band_sum   = '0;
            band_cnt   = '0;
            close_mark = close_mark + 13'(sbr_pkg::BANDS);
        end

        if (frame_end)
            restart_frame();
        else
            band_pos = p + 7'd1;
    endfunction

    function automatic logic [sbr_pkg::VAL_W-1:0] random_band();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return sbr_pkg::VAL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one band, with random gaps ahead of it outside the steady stretch; return at the next falling edge
    task automatic send_band(input logic [sbr_pkg::VAL_W-1:0] v);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        predict_band(v);
        @(negedge aclk);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic [sbr_pkg::IDX_W-1:0] idx,
                             input logic [sbr_pkg::CFG_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sbr_pkg::REG_OUT_BAND_COUNT: begin
                group_setting = data;
                restart_frame();
            end
            sbr_pkg::REG_SELECT_MODE: begin
                pick_mode = data[0];
                restart_frame();
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic plan_row_t band_row(input logic [sbr_pkg::VAL_W-1:0] v);
        plan_row_t r;
        r.kind    = ROW_BAND;
        r.idx     = sbr_pkg::REG_OUT_BAND_COUNT;
        r.data    = '0;
        r.band    = v;
        r.checked = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(input logic [sbr_pkg::VAL_W-1:0] v,
                                              input logic [sbr_pkg::VAL_W-1:0] want_value);
        plan_row_t r;
        r            = band_row(v);
        r.checked    = 1'b1;
        r.want.value = want_value;
        r.want.last  = 1'b0;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [sbr_pkg::IDX_W-1:0] idx,
                                          input logic [sbr_pkg::CFG_W-1:0] data);
        plan_row_t r;
        r      = band_row('0);
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Receiver side: stall at random, except in the steady stretch
    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        band_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_tdata), -1);
            end else begin
                exp_r = pending_q.pop_front();
                if (m_tdata !== exp_r.value)
                    report_mismatch("out_value", int'(m_tdata), int'(exp_r.value));
                if (m_tlast !== exp_r.last)
                    report_mismatch("last_of_frame", int'(m_tlast), int'(exp_r.last));
            end
        end
    end

    // Guard against a hung block
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        plan_row_t   plan[$];
        logic [6:0]  groups;
        logic        mode;
        int          extra;

        // Directed table; reset state is 75 groups in average mode
        plan = '{
            checked_row(8'd255, 8'd255),
            checked_row(8'd0, 8'd0),
            checked_row(8'd128, 8'd128),
            reg_row(sbr_pkg::REG_SELECT_MODE, 7'd1),
            checked_row(8'd77, 8'd77),          // band zero passed through first
            checked_row(8'd1, 8'd1),
            reg_row(sbr_pkg::REG_OUT_BAND_COUNT, 7'd0),  // zero groups act as one
            checked_row(8'd9, 8'd9),
            band_row(8'd250),
            reg_row(REG_UNUSED_A, 7'd127),      // ignored, frame carries on
            band_row(8'd3),
            reg_row(REG_UNUSED_B, 7'd0),
            reg_row(sbr_pkg::REG_OUT_BAND_COUNT, 7'd127),// clipped to the band count
            checked_row(8'd255, 8'd255),
            checked_row(8'd254, 8'd254),
            reg_row(sbr_pkg::REG_SELECT_MODE, 7'd0),
            reg_row(sbr_pkg::REG_OUT_BAND_COUNT, 7'd38), // groups of two bands
            band_row(8'd255),
            checked_row(8'd254, 8'd254),
            band_row(8'd1),
            band_row(8'd2),
            reg_row(sbr_pkg::REG_OUT_BAND_COUNT, 7'd75)
        };

        // Hold reset at the start, then release it
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_band(plan[i].band);
                if (plan[i].checked) begin
                    if (fresh_q.size() == 0)
                        report_mismatch("table row gave no result", 0, int'(plan[i].want.value));
                    else if (fresh_q[0] != plan[i].want)
                        report_mismatch("table row", int'(fresh_q[0].value),
                                        int'(plan[i].want.value));
                end
            end
        end

        // Random phases: one full frame each, then up to 30 bands of a frame that is cut short
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin groups = 7'd1;   mode = 1'b0; end
                1: begin groups = 7'd75;  mode = 1'b1; end
                2: begin groups = 7'd0;   mode = 1'b1; end
                3: begin groups = 7'd127; mode = 1'b0; end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        groups = 7'($urandom_range(1, 8));
                    else
                        groups = 7'($urandom_range(0, 127));
                    mode = 1'($urandom_range(0, 1));
                end
            endcase
            steady = (ph == 3);

            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                          7'($urandom_range(0, 127)));
            if ($urandom_range(0, 1)) begin
                write_reg(sbr_pkg::REG_SELECT_MODE, {6'($urandom_range(0, 63)), mode});
                write_reg(sbr_pkg::REG_OUT_BAND_COUNT, groups);
            end else begin
                write_reg(sbr_pkg::REG_OUT_BAND_COUNT, groups);
                write_reg(sbr_pkg::REG_SELECT_MODE, {6'($urandom_range(0, 63)), mode});
            end

            extra = $urandom_range(0, 30);
            for (int b = 0; b < sbr_pkg::BANDS + extra; b++)
                send_band(random_band());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then allow for stray results
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (pending_q.size() != 0)
            report_mismatch("results never delivered", 0, pending_q.size());

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/sbr_pkg.sv
rtl/sbr_divider.sv
rtl/sbr_datapath.sv
rtl/sbr_ctrl.sv
rtl/spectrum_band_reducer.sv
tb/testbench.sv
